/* rtl/rule_net_coalition_value_assert.svh */
// Assertion macros for the rule net coalition value checker.
// Expects clk and rst_n in the scope of every use.
`ifndef RULE_NET_COALITION_VALUE_ASSERT_SVH
`define RULE_NET_COALITION_VALUE_ASSERT_SVH

// same-cycle implication
`define RNC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rnc assertion failed");

// next-cycle implication
`define RNC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rnc assertion failed");

`endif

/* rtl/rnc_pkg.sv */
// Shared types and constants for the rule net coalition value block.
// No dependencies.
package rnc_pkg;

    localparam int unsigned MASK_W    = 32;
    localparam int unsigned INDEX_W   = 6;
    localparam int unsigned WEIGHT_W  = 32;
    localparam int unsigned SUM_W     = 40;
    localparam int unsigned COUNT_W   = 7;
    localparam int unsigned IN_DATA_W = 136;
    localparam int unsigned OUT_DATA_W = 48;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_EVAL  = 1'b1
    } req_type_t;

    // partial result handed from cell to cell
    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] sum;
        logic [COUNT_W-1:0]      count;
    } token_t;

    // rule write broadcast to every cell
    typedef struct packed {
        logic                       en;
        logic [INDEX_W-1:0]         index;
        logic [MASK_W-1:0]          required;
        logic [MASK_W-1:0]          forbidden;
        logic signed [WEIGHT_W-1:0] weight;
    } rule_wr_t;

endpackage

/* rtl/rnc_cell.sv */
// One cell of the rule chain: stores one rule and adds its weight to the
// passing token when the rule matches the coalition. Uses rnc_pkg.
module rnc_cell #(
    parameter int CELL_INDEX = 0,
    parameter int AGENT_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic [6:0]            rules_in_use,
    input  logic [AGENT_BITS-1:0] coalition,
    input  rnc_pkg::rule_wr_t     wr,
    input  rnc_pkg::token_t       tok_in,
    output rnc_pkg::token_t       tok_out
);

    logic [AGENT_BITS-1:0]                required_reg;
    logic [AGENT_BITS-1:0]                forbidden_reg;
    logic signed [rnc_pkg::WEIGHT_W-1:0]  weight_reg;
    logic                                 valid_reg;
    logic signed [rnc_pkg::SUM_W-1:0]     sum_reg;
    logic [rnc_pkg::COUNT_W-1:0]          count_reg;

    logic                                 wr_hit;
    logic                                 in_use;
    logic                                 match;
    logic signed [rnc_pkg::SUM_W:0]       sum_wide;
    logic signed [rnc_pkg::SUM_W-1:0]     sum_next;
    logic [rnc_pkg::COUNT_W-1:0]          count_next;

    assign wr_hit = wr.en && ({26'd0, wr.index} == 32'(CELL_INDEX));
    assign in_use = {25'd0, rules_in_use} > 32'(CELL_INDEX);
    assign match  = in_use
                    && ((required_reg & ~coalition) == '0)
                    && ((forbidden_reg & coalition) == '0);

    always_comb
    begin
        sum_wide = {tok_in.sum[rnc_pkg::SUM_W-1], tok_in.sum}
                   + {{(rnc_pkg::SUM_W + 1 - rnc_pkg::WEIGHT_W){weight_reg[rnc_pkg::WEIGHT_W-1]}},
                      weight_reg};
        sum_next   = tok_in.sum;
        count_next = tok_in.count;
        if (match)
        begin
            if (sum_wide[rnc_pkg::SUM_W] != sum_wide[rnc_pkg::SUM_W-1])
                sum_next = sum_wide[rnc_pkg::SUM_W] ? rnc_pkg::SUM_MIN : rnc_pkg::SUM_MAX;
            else
                sum_next = sum_wide[rnc_pkg::SUM_W-1:0];
            if (tok_in.count != rnc_pkg::COUNT_MAX)
                count_next = tok_in.count + 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            required_reg  <= wr.required[AGENT_BITS-1:0];
            forbidden_reg <= wr.forbidden[AGENT_BITS-1:0];
            weight_reg    <= wr.weight;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= tok_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    assign tok_out = '{valid: valid_reg, sum: sum_reg, count: count_reg};

endmodule

/* rtl/rule_net_coalition_value.sv */
// Rule net coalition value: top level, a chain of rnc_cell instances.
// Depends on rnc_pkg and rnc_cell.
//
// Usage:
//   s_* takes items. s_tuser selects the kind: write one rule or evaluate a
//   coalition. A write stores the rule in the cell named by rule_index
//   (indexes past the table are dropped) and gives no result. An evaluate
//   returns one result on m_*: the saturated sum of matching rule weights
//   and the match count.
//   cfg_* writes rules_in_use; cfg_ready is always high.
//   Flow: an evaluate is registered in the start register, then the token
//   walks one cell per cycle, while the output does not stall, through
//   MAX_RULES cells and lands in the output register. s_tready stays low
//   while a token is in the chain, so a new evaluate is taken only once the
//   last result is loaded; writes are taken one per cycle while idle.
//   Reset clears rules_in_use, the chain and the output register; stored
//   rules are undefined until written.
//   A stalled receiver holds the result; a finished token then waits in the
//   last cell and s_tready stays low until the output register frees.
module rule_net_coalition_value #(
    parameter int MAX_RULES  = 64,
    parameter int NUM_AGENTS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // rule_index, required_mask, forbidden_mask,
                                   // rule_weight, coalition_mask, 2 zero bits
    input  logic         s_tuser,  // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,  // coalition_value, rules_matched, 1 zero bit
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [6:0]   cfg_data  // rules_in_use
);

    localparam int AGENT_BITS = (NUM_AGENTS < 32) ? NUM_AGENTS : 32;

    logic [rnc_pkg::INDEX_W-1:0]          rule_index;
    logic [rnc_pkg::MASK_W-1:0]           required_mask;
    logic [rnc_pkg::MASK_W-1:0]           forbidden_mask;
    logic signed [rnc_pkg::WEIGHT_W-1:0]  rule_weight;
    logic [rnc_pkg::MASK_W-1:0]           coalition_mask;

    logic [6:0]                           rules_in_use_reg;
    logic                                 active_reg;
    logic                                 start_valid_reg;
    logic [AGENT_BITS-1:0]                coalition_reg;
    logic                                 out_valid_reg;
    logic signed [rnc_pkg::SUM_W-1:0]     out_sum_reg;
    logic [rnc_pkg::COUNT_W-1:0]          out_count_reg;

    logic                                 in_accept;
    logic                                 eval_accept;
    logic                                 advance;
    logic                                 out_load;
    rnc_pkg::rule_wr_t                    wr;
    rnc_pkg::token_t                      tok [MAX_RULES+1];

    assign rule_index     = s_tdata[5:0];
    assign required_mask  = s_tdata[37:6];
    assign forbidden_mask = s_tdata[69:38];
    assign rule_weight    = s_tdata[101:70];
    assign coalition_mask = s_tdata[133:102];

    assign s_tready    = !active_reg;
    assign cfg_ready   = 1'b1;
    assign in_accept   = s_tvalid && s_tready;
    assign eval_accept = in_accept && (rnc_pkg::req_type_t'(s_tuser) == rnc_pkg::REQ_EVAL);

    assign wr = '{en:        in_accept
                             && (rnc_pkg::req_type_t'(s_tuser) == rnc_pkg::REQ_WRITE),
                  index:     rule_index,
                  required:  required_mask,
                  forbidden: forbidden_mask,
                  weight:    rule_weight};

    assign out_load = tok[MAX_RULES].valid && (!out_valid_reg || m_tready);
    assign advance  = !tok[MAX_RULES].valid || !out_valid_reg || m_tready;

    assign tok[0] = '{valid: start_valid_reg, sum: '0, count: '0};

    for (genvar i = 0; i < MAX_RULES; i++)
    begin : g_cell
        rnc_cell #(
            .CELL_INDEX (i),
            .AGENT_BITS (AGENT_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .advance      (advance),
            .rules_in_use (rules_in_use_reg),
            .coalition    (coalition_reg),
            .wr           (wr),
            .tok_in       (tok[i]),
            .tok_out      (tok[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rules_in_use_reg <= '0;
            active_reg       <= 1'b0;
            start_valid_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                rules_in_use_reg <= cfg_data;
            if (eval_accept)
                active_reg <= 1'b1;
            else if (out_load)
                active_reg <= 1'b0;
            if (advance)
                start_valid_reg <= eval_accept;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_accept)
            coalition_reg <= coalition_mask[AGENT_BITS-1:0];
        if (out_load)
        begin
            out_sum_reg   <= tok[MAX_RULES].sum;
            out_count_reg <= tok[MAX_RULES].count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_sum_reg};

endmodule

/* rtl/rnc_checker.sv */
// Port-level checks for rule_net_coalition_value, attached by bind.
// Depends on rnc_pkg and rule_net_coalition_value_assert.svh.
`include "rule_net_coalition_value_assert.svh"

module rnc_checker #(
    parameter int MAX_RULES = 64
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    logic is_eval;
    logic is_write;

    assign is_eval  = rnc_pkg::req_type_t'(s_tuser) == rnc_pkg::REQ_EVAL;
    assign is_write = rnc_pkg::req_type_t'(s_tuser) == rnc_pkg::REQ_WRITE;

    `RNC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `RNC_ASSERT_NEXT(a_eval_blocks, s_tvalid && s_tready && is_eval, !s_tready)
    `RNC_ASSERT_NOW(a_count_range, m_tvalid,
        !m_tdata[47] && ({25'd0, m_tdata[46:40]} <= 32'(MAX_RULES)))
    `RNC_ASSERT_NEXT(a_write_no_result, s_tvalid && s_tready && is_write && !m_tvalid,
        !m_tvalid)

endmodule

bind rule_net_coalition_value rnc_checker #(.MAX_RULES(MAX_RULES)) u_rnc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
